// File: rtl/bfr_pkg.sv
// Shared constants, types and helper functions of the bitstream field reader.
package bfr_pkg;

	// Ring buffer geometry
	localparam int BUFFER_BYTES = 16;
	localparam int IDX_W        = $clog2(BUFFER_BYTES);
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
	localparam int AV_W         = $clog2(BUFFER_BYTES * 8 + 1);

	// Datapath widths
	localparam int WIN_W = 72;
	localparam int VAL_W = 64;

	// Widest fixed read and longest accepted golomb prefix
	localparam logic [5:0] MAX_FIX    = 6'd32;
	localparam int         MAX_PREFIX = 31;

	typedef enum logic [1:0] {
		K_PUSH,
		K_FIXED,
		K_GOLOMB,
		K_EBML
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK,
		STAT_UNDERRUN,
		STAT_LONG_PREFIX,
		STAT_UNALIGNED,
		STAT_ZERO_LEAD,
		STAT_FULL
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_SCAN_REQ,
		FSM_SCAN_CHK,
		FSM_GOL_DEC,
		FSM_LEAD_REQ,
		FSM_LEAD_CHK,
		FSM_TAKE,
		FSM_FINISH,
		FSM_REPLY
	} state_t;

	// Leading zeros of a byte, 8 when the byte is zero
	function automatic logic [3:0] lzc8(input logic [7:0] b);
		logic [3:0] n;
		logic       hit;
		n   = 4'd8;
		hit = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!hit && b[i]) begin
				n   = 4'(7 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// Ring pointer plus a byte count of at most the buffer size
	function automatic logic [IDX_W-1:0] ptr_add(input logic [IDX_W-1:0] p,
	                                            input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
		if (s >= (CNT_W+1)'(BUFFER_BYTES)) begin
			s = s - (CNT_W+1)'(BUFFER_BYTES);
		end
		return IDX_W'(s);
	endfunction

	// Bytes touched by a field of bits starting at bit offset off
	function automatic logic [3:0] bytes_of(input logic [2:0] off, input logic [6:0] bits);
		logic [7:0] t;
		t = 8'(off) + 8'(bits) + 8'd7;
		return 4'(t >> 3);
	endfunction

endpackage

// File: rtl/bitstream_field_reader.sv
// Bitstream field reader: byte ring buffer read MSB-first as fixed, golomb and ebml fields.
//
// Bytes pushed in are kept in a ring RAM and read back MSB-first as one
// bitstream. One word is handled at a time. A push, or a result that needs no
// data, goes from acceptance straight to the reply step.
// The RAM read port is registered and delivers one byte per cycle, and a
// read fetches the bytes the field touches (up to 8). A fixed read goes
// straight to the fetch, an ebml read first reads its lead byte, and an
// exp-golomb read first scans its prefix one byte per visit and then decodes it.
// Ebml lead byte errors and golomb prefix errors go to the reply step from their
// check. A result waiting at the output holds the following word at
// its reply step, and no new word is accepted until that result moves out.
// An underrun drops all buffered bytes.
module bitstream_field_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [5:0]  read_width,
	input  logic        variant,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [2:0]  status
);

	localparam int IW = bfr_pkg::IDX_W;
	localparam int CW = bfr_pkg::CNT_W;
	localparam int AW = bfr_pkg::AV_W;

	bfr_pkg::state_t  state_q, state_d;
	bfr_pkg::kind_t   op_q, op_d;
	logic             var_q, var_d;
	logic [IW-1:0]    rd_q, rd_d, wr_q, wr_d, addr_q, addr_d;
	logic [CW-1:0]    cnt_q, cnt_d, left_q, left_d;
	logic [2:0]       off_q, off_d;
	logic [3:0]       iss_q, iss_d, rcv_q, rcv_d, nb_q, nb_d, len_q, len_d;
	logic             pend_q, pend_d, first_q, first_d;
	logic [6:0]       bits_q, bits_d;
	logic [71:0]      win_q, win_d;
	logic [AW-1:0]    z_q, z_d;
	logic [63:0]      res_val_q, res_val_d, value_q;
	bfr_pkg::status_t res_stat_q, res_stat_d, status_q;
	logic             out_valid_q;

	logic             ram_we;
	logic [7:0]       ram_rdata;

	logic             in_acc, out_load, issue;
	bfr_pkg::kind_t   in_kind;
	logic [AW-1:0]    av;
	logic [5:0]       w_sat;
	logic             fix_zero, fix_under;
	logic [7:0]       scan_b;
	logic [3:0]       scan_vb;
	logic             scan_zero, scan_end;
	logic [AW-1:0]    z_sum;
	logic             gol_long, gol_short;
	logic [AW:0]      z_tot;
	logic [CW-1:0]    z_bytes;
	logic [6:0]       gol_bits;
	logic             lead_zero, lead_short;
	logic [3:0]       lead_len;
	logic [6:0]       tk_tot;
	logic [CW-1:0]    tk_bytes;
	logic [2:0]       tk_sh;
	logic [71:0]      tk_raw;
	logic [63:0]      tk_mask, tk_field, tk_mask7, tk_val;

	// Byte store
	bfr_ram #(.WIDTH(8), .DEPTH(bfr_pkg::BUFFER_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (data_byte),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Handshake
	assign in_ready  = (state_q == bfr_pkg::FSM_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign in_kind   = bfr_pkg::kind_t'(kind);
	assign out_load  = (state_q == bfr_pkg::FSM_REPLY) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// Buffer level and fixed-read checks
	assign av        = (AW'(cnt_q) << 3) - AW'(off_q);
	assign w_sat     = (read_width > bfr_pkg::MAX_FIX) ? bfr_pkg::MAX_FIX : read_width;
	assign fix_zero  = (w_sat == 6'd0);
	assign fix_under = (av < AW'(w_sat));

	// Golomb prefix scan, one byte per visit
	assign scan_b    = first_q ? (ram_rdata << off_q) : ram_rdata;
	assign scan_vb   = first_q ? (4'd8 - {1'b0, off_q}) : 4'd8;
	assign scan_zero = (scan_b == 8'd0);
	assign scan_end  = (left_q == CW'(1));
	assign z_sum     = z_q + AW'(scan_zero ? scan_vb : bfr_pkg::lzc8(scan_b));

	// Golomb decision and prefix skip
	assign gol_long  = (z_q > AW'(bfr_pkg::MAX_PREFIX));
	assign gol_short = (av < AW'({z_q[4:0], 1'b1}));
	assign z_tot     = (AW+1)'(off_q) + (AW+1)'(z_q);
	assign z_bytes   = CW'(z_tot >> 3);
	assign gol_bits  = 7'(z_q[4:0]) + 7'd1;

	// Ebml lead byte
	assign lead_zero  = (ram_rdata == 8'd0);
	assign lead_len   = bfr_pkg::lzc8(ram_rdata) + 4'd1;
	assign lead_short = (cnt_q < CW'(lead_len));

	// Field extraction from the fetched window
	assign issue    = (state_q == bfr_pkg::FSM_TAKE) && (iss_q != nb_q);
	assign tk_tot   = 7'(off_q) + bits_q;
	assign tk_bytes = CW'(tk_tot[6:3]);
	assign tk_sh    = 3'd0 - tk_tot[2:0];
	assign tk_raw   = win_q >> tk_sh;
	assign tk_mask  = (bits_q == 7'd64) ? '1 : ((64'd1 << bits_q) - 64'd1);
	assign tk_field = tk_raw[63:0] & tk_mask;
	assign tk_mask7 = (64'd1 << (6'(len_q) * 6'd7)) - 64'd1;

	always_comb begin
		unique case (op_q)
			bfr_pkg::K_GOLOMB: begin
				if (var_q) begin
					tk_val = tk_field[0] ? (64'd0 - (tk_field >> 1)) : (tk_field >> 1);
				end else begin
					tk_val = tk_field - 64'd1;
				end
			end
			bfr_pkg::K_EBML: tk_val = var_q ? tk_field : (tk_field & tk_mask7);
			default:         tk_val = tk_field;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfr_pkg::FSM_IDLE: begin
				if (in_acc) begin
					unique case (in_kind)
						bfr_pkg::K_PUSH:   state_d = bfr_pkg::FSM_REPLY;
						bfr_pkg::K_FIXED:  state_d = (fix_zero || fix_under) ?
						                             bfr_pkg::FSM_REPLY : bfr_pkg::FSM_TAKE;
						bfr_pkg::K_GOLOMB: state_d = (av == '0) ?
						                             bfr_pkg::FSM_REPLY : bfr_pkg::FSM_SCAN_REQ;
						bfr_pkg::K_EBML:   state_d = (cnt_q == '0 || off_q != 3'd0) ?
						                             bfr_pkg::FSM_REPLY : bfr_pkg::FSM_LEAD_REQ;
						default:           state_d = bfr_pkg::FSM_REPLY;
					endcase
				end
			end
			bfr_pkg::FSM_SCAN_REQ: state_d = bfr_pkg::FSM_SCAN_CHK;
			bfr_pkg::FSM_SCAN_CHK: begin
				if (!scan_zero) begin
					state_d = bfr_pkg::FSM_GOL_DEC;
				end else begin
					state_d = scan_end ? bfr_pkg::FSM_REPLY : bfr_pkg::FSM_SCAN_REQ;
				end
			end
			bfr_pkg::FSM_GOL_DEC: state_d = (gol_long || gol_short) ?
			                                bfr_pkg::FSM_REPLY : bfr_pkg::FSM_TAKE;
			bfr_pkg::FSM_LEAD_REQ: state_d = bfr_pkg::FSM_LEAD_CHK;
			bfr_pkg::FSM_LEAD_CHK: state_d = (lead_zero || lead_short) ?
			                                 bfr_pkg::FSM_REPLY : bfr_pkg::FSM_TAKE;
			bfr_pkg::FSM_TAKE: begin
				if (rcv_q == nb_q) begin
					state_d = bfr_pkg::FSM_FINISH;
				end
			end
			bfr_pkg::FSM_FINISH: state_d = bfr_pkg::FSM_REPLY;
			bfr_pkg::FSM_REPLY: begin
				if (out_load) begin
					state_d = bfr_pkg::FSM_IDLE;
				end
			end
			default: state_d = bfr_pkg::FSM_IDLE;
		endcase
	end

	// Datapath and buffer pointer updates
	always_comb begin
		op_d       = op_q;
		var_d      = var_q;
		rd_d       = rd_q;
		wr_d       = wr_q;
		cnt_d      = cnt_q;
		off_d      = off_q;
		addr_d     = addr_q;
		iss_d      = iss_q;
		rcv_d      = rcv_q;
		nb_d       = nb_q;
		len_d      = len_q;
		pend_d     = 1'b0;
		first_d    = first_q;
		left_d     = left_q;
		bits_d     = bits_q;
		win_d      = win_q;
		z_d        = z_q;
		res_val_d  = res_val_q;
		res_stat_d = res_stat_q;
		ram_we     = 1'b0;
		unique case (state_q)
			bfr_pkg::FSM_IDLE: begin
				if (in_acc) begin
					op_d       = in_kind;
					var_d      = variant;
					res_val_d  = '0;
					res_stat_d = bfr_pkg::STAT_OK;
					addr_d     = rd_q;
					iss_d      = '0;
					rcv_d      = '0;
					unique case (in_kind)
						bfr_pkg::K_PUSH: begin
							if (cnt_q >= CW'(bfr_pkg::BUFFER_BYTES)) begin
								res_stat_d = bfr_pkg::STAT_FULL;
							end else begin
								ram_we = 1'b1;
								wr_d   = bfr_pkg::ptr_add(wr_q, CW'(1));
								cnt_d  = cnt_q + CW'(1);
							end
						end
						bfr_pkg::K_FIXED: begin
							if (!fix_zero && fix_under) begin
								cnt_d      = '0;
								rd_d       = wr_q;
								off_d      = 3'd0;
								res_stat_d = bfr_pkg::STAT_UNDERRUN;
							end
							bits_d = 7'(w_sat);
							nb_d   = bfr_pkg::bytes_of(off_q, 7'(w_sat));
						end
						bfr_pkg::K_GOLOMB: begin
							if (av == '0) begin
								cnt_d      = '0;
								rd_d       = wr_q;
								off_d      = 3'd0;
								res_stat_d = bfr_pkg::STAT_UNDERRUN;
							end
							z_d     = '0;
							left_d  = cnt_q;
							first_d = 1'b1;
						end
						bfr_pkg::K_EBML: begin
							if (cnt_q == '0) begin
								cnt_d      = '0;
								rd_d       = wr_q;
								off_d      = 3'd0;
								res_stat_d = bfr_pkg::STAT_UNDERRUN;
							end else if (off_q != 3'd0) begin
								res_stat_d = bfr_pkg::STAT_UNALIGNED;
							end
						end
						default: res_stat_d = bfr_pkg::STAT_OK;
					endcase
				end
			end
			bfr_pkg::FSM_SCAN_REQ: addr_d = bfr_pkg::ptr_add(addr_q, CW'(1));
			bfr_pkg::FSM_SCAN_CHK: begin
				z_d     = z_sum;
				first_d = 1'b0;
				left_d  = left_q - CW'(1);
				if (scan_zero && scan_end) begin
					cnt_d      = '0;
					rd_d       = wr_q;
					off_d      = 3'd0;
					res_stat_d = bfr_pkg::STAT_UNDERRUN;
				end
			end
			bfr_pkg::FSM_GOL_DEC: begin
				if (!gol_long && gol_short) begin
					cnt_d      = '0;
					rd_d       = wr_q;
					off_d      = 3'd0;
					res_stat_d = bfr_pkg::STAT_UNDERRUN;
				end else begin
					// skip the zero run, then fetch the codeword unless the prefix is too long
					rd_d   = bfr_pkg::ptr_add(rd_q, z_bytes);
					cnt_d  = cnt_q - z_bytes;
					off_d  = z_tot[2:0];
					addr_d = bfr_pkg::ptr_add(rd_q, z_bytes);
					bits_d = gol_bits;
					nb_d   = bfr_pkg::bytes_of(z_tot[2:0], gol_bits);
					iss_d  = '0;
					rcv_d  = '0;
					if (gol_long) begin
						res_stat_d = bfr_pkg::STAT_LONG_PREFIX;
					end
				end
			end
			bfr_pkg::FSM_LEAD_REQ: addr_d = rd_q;
			bfr_pkg::FSM_LEAD_CHK: begin
				iss_d  = '0;
				rcv_d  = '0;
				len_d  = lead_len;
				nb_d   = lead_len;
				bits_d = {lead_len, 3'b000};
				if (lead_zero) begin
					rd_d       = bfr_pkg::ptr_add(rd_q, CW'(1));
					cnt_d      = cnt_q - CW'(1);
					res_stat_d = bfr_pkg::STAT_ZERO_LEAD;
				end else if (lead_short) begin
					cnt_d      = '0;
					rd_d       = wr_q;
					off_d      = 3'd0;
					res_stat_d = bfr_pkg::STAT_UNDERRUN;
				end
			end
			bfr_pkg::FSM_TAKE: begin
				// one byte read issued and one captured per cycle
				if (issue) begin
					addr_d = bfr_pkg::ptr_add(addr_q, CW'(1));
					iss_d  = iss_q + 4'd1;
				end
				pend_d = issue;
				if (pend_q) begin
					win_d = {win_q[63:0], ram_rdata};
					rcv_d = rcv_q + 4'd1;
				end
			end
			bfr_pkg::FSM_FINISH: begin
				res_val_d = tk_val;
				rd_d      = bfr_pkg::ptr_add(rd_q, tk_bytes);
				cnt_d     = cnt_q - tk_bytes;
				off_d     = tk_tot[2:0];
			end
			default: res_stat_d = res_stat_q;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfr_pkg::FSM_IDLE;
			rd_q        <= '0;
			wr_q        <= '0;
			cnt_q       <= '0;
			off_q       <= '0;
			pend_q      <= 1'b0;
			iss_q       <= '0;
			rcv_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			cnt_q   <= cnt_d;
			off_q   <= off_d;
			pend_q  <= pend_d;
			iss_q   <= iss_d;
			rcv_q   <= rcv_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		var_q      <= var_d;
		addr_q     <= addr_d;
		nb_q       <= nb_d;
		len_q      <= len_d;
		first_q    <= first_d;
		left_q     <= left_d;
		bits_q     <= bits_d;
		win_q      <= win_d;
		z_q        <= z_d;
		res_val_q  <= res_val_d;
		res_stat_q <= res_stat_d;
		if (out_load) begin
			value_q  <= res_val_q;
			status_q <= res_stat_q;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(bfr_pkg::BUFFER_BYTES))
		else $error("buffered count exceeds buffer size");

	a_off_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		off_q != 3'd0 |-> cnt_q != '0)
		else $error("bit offset set with empty buffer");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> rd_q == wr_q)
		else $error("empty buffer with split pointers");

	a_take_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfr_pkg::FSM_TAKE && pend_q) |-> rcv_q < nb_q)
		else $error("fetch captured more bytes than needed");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_kind == bfr_pkg::K_PUSH && cnt_q < CW'(bfr_pkg::BUFFER_BYTES))
		|=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("push did not grow the buffer");
`endif

endmodule

// File: rtl/bfr_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the bitstream field reader.
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [5:0]  read_width;
	logic        variant;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] value;
	logic [2:0]  status;

	bitstream_field_reader uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .data_byte(data_byte), .read_width(read_width), .variant(variant),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status)
	);

	// Predicted stream state
	logic [7:0]       ring [bfr_pkg::BUFFER_BYTES];
	int unsigned      rd_idx, wr_idx, fill, bit_off;
	logic [63:0]      exp_value [$];
	logic [2:0]       exp_status [$];
	int               errors;
	int               results_seen;
	int               idle_cnt;
	bit               calm;
	bit               done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch #%0d on %s: got %h want %h", results_seen, what, got, want);
		errors++;
	endtask

	function automatic int unsigned bits_left();
		return (fill * 8 >= bit_off) ? fill * 8 - bit_off : 0;
	endfunction

	function automatic logic peek(input int unsigned p);
		int unsigned pos;
		pos = bit_off + p;
		return ring[(rd_idx + (pos >> 3)) % bfr_pkg::BUFFER_BYTES][7 - (pos & 7)];
	endfunction

	function automatic void skip(input int unsigned n);
		int unsigned tot, nb;
		tot = bit_off + n;
		nb  = tot >> 3;
		if (nb > fill) nb = fill;
		rd_idx  = (rd_idx + nb) % bfr_pkg::BUFFER_BYTES;
		fill    = fill - nb;
		bit_off = tot & 7;
	endfunction

	function automatic logic [63:0] grab(input int unsigned n);
		logic [63:0] v;
		v = '0;
		for (int unsigned i = 0; i < n; i++) v = {v[62:0], peek(i)};
		skip(n);
		return v;
	endfunction

	function automatic void flush();
		fill    = 0;
		rd_idx  = wr_idx;
		bit_off = 0;
	endfunction

	// Works out the result of one word and queues it
	function automatic void predict_field(input bfr_pkg::kind_t k, input logic [7:0] b,
	                                      input logic [5:0] w, input logic var_bit);
		logic [63:0]      v, cw, mag;
		bfr_pkg::status_t st;
		int unsigned      wd, av, z, len;
		logic [7:0]       lead;
		v  = '0;
		st = bfr_pkg::STAT_OK;
		case (k)
			bfr_pkg::K_PUSH: begin
				if (fill >= bfr_pkg::BUFFER_BYTES) st = bfr_pkg::STAT_FULL;
				else begin
					ring[wr_idx] = b;
					wr_idx = (wr_idx + 1) % bfr_pkg::BUFFER_BYTES;
					fill++;
				end
			end
			bfr_pkg::K_FIXED: begin
				wd = (w > 32) ? 32 : w;
				if (wd != 0) begin
					if (bits_left() < wd) begin
						flush();
						st = bfr_pkg::STAT_UNDERRUN;
					end else v = grab(wd);
				end
			end
			bfr_pkg::K_GOLOMB: begin
				av = bits_left();
				z  = 0;
				while (z < av && peek(z) == 1'b0) z++;
				if (z >= av) begin
					flush();
					st = bfr_pkg::STAT_UNDERRUN;
				end else if (z > 31) begin
					skip(z);
					st = bfr_pkg::STAT_LONG_PREFIX;
				end else if (av < 2 * z + 1) begin
					flush();
					st = bfr_pkg::STAT_UNDERRUN;
				end else begin
					skip(z);
					cw = grab(z + 1);
					mag = cw >> 1;
					if (var_bit) v = cw[0] ? -mag : mag;
					else v = cw - 1;
				end
			end
			default: begin
				if (fill == 0) begin
					flush();
					st = bfr_pkg::STAT_UNDERRUN;
				end else if (bit_off != 0) st = bfr_pkg::STAT_UNALIGNED;
				else begin
					lead = ring[rd_idx];
					len  = 1;
					while (len <= 8 && lead[8 - len] == 1'b0) len++;
					if (len > 8) begin
						skip(8);
						st = bfr_pkg::STAT_ZERO_LEAD;
					end else if (fill < len) begin
						flush();
						st = bfr_pkg::STAT_UNDERRUN;
					end else begin
						v = grab(8 * len);
						if (!var_bit) v &= (64'd1 << (7 * len)) - 1;
					end
				end
			end
		endcase
		if (st != bfr_pkg::STAT_OK) v = '0;
		exp_value.push_back(v);
		exp_status.push_back(st);
	endfunction

	// Sends one word, with random idle bursts ahead of it
	task automatic send_word(input bfr_pkg::kind_t k, input logic [7:0] b,
	                         input logic [5:0] w, input logic var_bit);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		predict_field(k, b, w, var_bit);
		in_valid   <= 1'b1;
		kind       <= k;
		data_byte  <= b;
		read_width <= w;
		variant    <= var_bit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_word(bfr_pkg::K_PUSH, b, 6'($urandom), 1'($urandom));
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (exp_value.size() == 0) begin
				report("unexpected word", value, '0);
			end else begin
				if (value !== exp_value[0]) report("value", value, exp_value[0]);
				if (status !== exp_status[0]) report("status", 64'(status), 64'(exp_status[0]));
				void'(exp_value.pop_front());
				void'(exp_status.pop_front());
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Watchdog on cycles without a transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || done) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_push_full();
		for (int i = 0; i < bfr_pkg::BUFFER_BYTES + 2; i++) push_byte(8'(i * 37 + 1));
	endtask

	task automatic test_fixed_edges();
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd0, 1'b0);
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd63, 1'b0);
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd32, 1'b1);
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd1, 1'b0);
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd40, 1'b0);
	endtask

	task automatic test_golomb_edges();
		push_byte(8'h80); push_byte(8'h5F); push_byte(8'h00);
		push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h01);
		send_word(bfr_pkg::K_GOLOMB, 8'h00, 6'd0, 1'b0);
		send_word(bfr_pkg::K_GOLOMB, 8'h00, 6'd0, 1'b1);
		send_word(bfr_pkg::K_GOLOMB, 8'h00, 6'd0, 1'b1);
		send_word(bfr_pkg::K_GOLOMB, 8'h00, 6'd0, 1'b0);
		send_word(bfr_pkg::K_GOLOMB, 8'h00, 6'd0, 1'b0);
	endtask

	task automatic test_ebml_edges();
		send_word(bfr_pkg::K_EBML, 8'h00, 6'd0, 1'b0);
		push_byte(8'hFF); push_byte(8'h00); push_byte(8'h01);
		push_byte(8'hFF); push_byte(8'hEE); push_byte(8'hDD); push_byte(8'hCC);
		push_byte(8'hBB); push_byte(8'hAA); push_byte(8'h99);
		send_word(bfr_pkg::K_EBML, 8'h00, 6'd0, 1'b1);
		send_word(bfr_pkg::K_EBML, 8'h00, 6'd0, 1'b0);
		send_word(bfr_pkg::K_EBML, 8'h00, 6'd0, 1'b0);
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd3, 1'b0);
		send_word(bfr_pkg::K_EBML, 8'h00, 6'd0, 1'b0);
		send_word(bfr_pkg::K_FIXED, 8'h00, 6'd5, 1'b0);
		send_word(bfr_pkg::K_EBML, 8'h00, 6'd0, 1'b0);
	endtask

	// Random mix of pushes and fixed, golomb and ebml reads, with some noise
	task automatic test_random(input int n);
		int             sel;
		bfr_pkg::kind_t k;
		logic [7:0]     b;
		for (int i = 0; i < n; i++) begin
			if (i > n - 200) calm = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 45) k = bfr_pkg::K_PUSH;
			else if (sel < 65) k = bfr_pkg::K_FIXED;
			else if (sel < 85) k = bfr_pkg::K_GOLOMB;
			else k = bfr_pkg::K_EBML;
			b = 8'($urandom);
			if (k == bfr_pkg::K_PUSH && $urandom_range(0, 3) == 0)
				b = b >> $urandom_range(0, 8);
			send_word(k, b,
				($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12)),
				1'($urandom));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = '0;
		data_byte  = '0;
		read_width = '0;
		variant    = 1'b0;
		errors = 0; results_seen = 0; idle_cnt = 0; calm = 0; done = 0;
		rd_idx = 0; wr_idx = 0; fill = 0; bit_off = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_push_full();
		test_fixed_edges();
		test_golomb_edges();
		test_ebml_edges();
		test_random(1700);
		in_valid <= 1'b0;
		while (exp_value.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		done = 1'b1;
		$display("checked %0d result words over pushes, fixed, golomb and ebml reads",
			results_seen);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

// File: sim.f
rtl/bfr_pkg.sv
rtl/bfr_ram.sv
rtl/bitstream_field_reader.sv
sim/tb_top.sv
